// ===== rtl/core/bsf_pkg.sv =====
package bsf_pkg;

    // default build limits
    localparam int DEF_MAX_SNAKE_LENGTH = 31;
    localparam int DEF_MAX_WIDTH        = 64;
    localparam int DEF_MAX_HEIGHT       = 64;

    // field widths
    localparam int MODE_W    = 2;
    localparam int ELAPSED_W = 22;
    localparam int COLOR_W   = 24;
    localparam int COORD_W   = 6;
    localparam int WREG_W    = 7;
    localparam int HREG_W    = 7;
    localparam int LREG_W    = 5;
    localparam int DUR_W     = 22;

    // stream packing
    localparam int S_TDATA_W = 48;
    localparam int PIX_BITS  = 2 * COORD_W + COLOR_W;
    localparam int M_TDATA_W = 40;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 22;

    // event kinds
    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FRAME  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DURATION = 2'd3;

    // register reset values
    localparam logic [WREG_W-1:0] WIDTH_RST    = 7'd16;
    localparam logic [HREG_W-1:0] HEIGHT_RST   = 7'd16;
    localparam logic [LREG_W-1:0] LENGTH_RST   = 5'd8;
    localparam logic [DUR_W-1:0]  DURATION_RST = 22'd0;

endpackage

// ===== rtl/core/bsf_div.sv =====
module bsf_div #(
    parameter int QW = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [bsf_pkg::DUR_W+QW-1:0]   num,
    input  logic [bsf_pkg::DUR_W-1:0]      den,
    output logic                           done,
    output logic [QW-1:0]                  quot
);
    import bsf_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic [DUR_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]    low_reg, low_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DUR_W:0]   trial;
    logic [DUR_W:0]   diff;
    logic             ge;

    // one restoring step: shift in the next numerator bit, try to subtract
    assign trial = {rem_reg, low_reg[QW-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = trial >= {1'b0, den};

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            // quotient fits QW bits, so the high part is already below den
            rem_next = num[DUR_W+QW-1:QW];
            low_next = num[QW-1:0];
            cnt_next = CW'(QW);
            run_next = 1'b1;
        end else if (run_reg) begin
            rem_next = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
            low_next = {low_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

// ===== rtl/core/border_snake_frame_generator.sv =====
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+------------------------------------------
// s_        | in        | s_tvalid / s_tready   | tuser: mode; tdata: elapsed_ms, color
// m_        | out       | m_tvalid / m_tready   | tdata: pixel_x, pixel_y, color; tlast
// cfg_      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// start, cancel and idle frames leave the block in its idle state. a lit frame
// runs, per snake, one setup, one multiply, QW steps of the shared restoring
// divider (QW = quotient width, 8 by default) and a walk over the trailing
// pixels, then the center and flush states; s_tready is low for that time.
// reset (aresetn low, synchronous) disarms the block and loads the register
// defaults. a stalled m_ side holds the walk once the pending pixel needs
// the output register.
module border_snake_frame_generator #(
    parameter int MAX_SNAKE_LENGTH = bsf_pkg::DEF_MAX_SNAKE_LENGTH,
    parameter int MAX_WIDTH        = bsf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT       = bsf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input transactions
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bsf_pkg::S_TDATA_W-1:0]      s_tdata,   // elapsed_ms, current_color
    input  logic [bsf_pkg::MODE_W-1:0]         s_tuser,   // mode
    // pixel transactions
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bsf_pkg::M_TDATA_W-1:0]      m_tdata,   // pixel_x, pixel_y, pixel_color
    output logic                               m_tlast,   // last_pixel
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bsf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bsf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bsf_pkg::*;

    // effective limits (registers are 7 bits wide)
    localparam int EW = (MAX_WIDTH  < 127) ? MAX_WIDTH  : 127;
    localparam int EH = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
    localparam int WW = $clog2(EW + 1);
    localparam int HW = $clog2(EH + 1);
    localparam int LW = $clog2(MAX_SNAKE_LENGTH + 1);
    localparam int SW = $clog2(EW + EH - 1 + MAX_SNAKE_LENGTH + 1);
    localparam int PW = (SW + 1 > COORD_W) ? SW + 1 : COORD_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_CENTER = 3'd5;
    localparam logic [2:0] ST_FLUSH  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic               running_reg, running_next;
    logic [WREG_W-1:0]  cfg_w_reg;
    logic [HREG_W-1:0]  cfg_h_reg;
    logic [LREG_W-1:0]  cfg_len_reg;
    logic [DUR_W-1:0]   cfg_dur_reg;

    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [COLOR_W-1:0]   color_reg, color_next;
    logic                 center_reg, center_next;
    logic                 side_reg, side_next;
    logic [WW-1:0]        w_reg, w_next;
    logic [HW-1:0]        h_reg, h_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [SW-1:0]        plen_reg, plen_next;
    logic [SW-1:0]        sum_reg, sum_next;
    logic [PW-1:0]        b1_reg, b1_next;
    logic [PW-1:0]        b2_reg, b2_next;
    logic [PW-1:0]        bb_reg, bb_next;
    logic [PW-1:0]        sx_reg, sx_next;
    logic [PW-1:0]        tb_reg, tb_next;
    logic [SW-1:0]        idx_reg, idx_next;
    logic [LW-1:0]        cnt_reg, cnt_next;

    logic               pend_valid_reg, pend_valid_next;
    logic [COORD_W-1:0] pend_x_reg, pend_x_next;
    logic [COORD_W-1:0] pend_y_reg, pend_y_next;
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] out_x_reg, out_x_next;
    logic [COORD_W-1:0] out_y_reg, out_y_next;
    logic [COLOR_W-1:0] out_color_reg, out_color_next;
    logic               out_last_reg, out_last_next;

    logic                 accept;
    logic [MODE_W-1:0]    in_mode;
    logic [ELAPSED_W-1:0] in_elapsed;
    logic [COLOR_W-1:0]   in_color;
    logic [WW-1:0]        w_clamp;
    logic [HW-1:0]        h_clamp;
    logic [LW-1:0]        len_clamp;
    logic [ELAPSED_W+3:0] ten_e;
    logic [ELAPSED_W+3:0] three_d;

    logic [PW-1:0] wp, hp, cp, ap, b1c, b2c, plenc;
    logic [PW-1:0] idxp;
    logic [PW-1:0] px, py;
    logic          pix_ok;
    logic          stall;

    logic                      div_start;
    logic [DUR_W+SW-1:0]       div_num;
    logic                      div_done;
    logic [SW-1:0]             div_quot;

    assign in_mode    = s_tuser;
    assign in_elapsed = s_tdata[ELAPSED_W-1:0];
    assign in_color   = s_tdata[ELAPSED_W+COLOR_W-1:ELAPSED_W];
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    // clamp the size registers to the supported range
    always_comb begin
        if (int'(cfg_w_reg) < 2)       w_clamp = WW'(2);
        else if (int'(cfg_w_reg) > EW) w_clamp = WW'(EW);
        else                           w_clamp = WW'(cfg_w_reg);
        if (int'(cfg_h_reg) < 2)       h_clamp = HW'(2);
        else if (int'(cfg_h_reg) > EH) h_clamp = HW'(EH);
        else                           h_clamp = HW'(cfg_h_reg);
        if (int'(cfg_len_reg) > MAX_SNAKE_LENGTH) len_clamp = LW'(MAX_SNAKE_LENGTH);
        else                                      len_clamp = LW'(cfg_len_reg);
    end

    // bottom-center pixel stays while 10 * elapsed < 3 * duration
    assign ten_e   = {1'b0, in_elapsed, 3'b000} + {3'b000, in_elapsed, 1'b0};
    assign three_d = {3'b000, cfg_dur_reg, 1'b0} + {4'b0000, cfg_dur_reg};

    // path geometry of the current side
    always_comb begin
        wp    = PW'(w_reg);
        hp    = PW'(h_reg);
        cp    = wp >> 1;
        ap    = wp - PW'(1) - cp;
        b1c   = side_reg ? ap : cp;
        b2c   = b1c + hp - PW'(1);
        plenc = (b1c << 1) + hp - PW'(1);
    end

    // coordinates of path index idx_reg
    assign idxp = PW'(idx_reg);
    always_comb begin
        if (idxp < b1_reg) begin
            px = side_reg ? (bb_reg + idxp) : (bb_reg - idxp);
            py = hp - PW'(1);
        end else if (idxp < b2_reg) begin
            px = sx_reg;
            py = b2_reg - PW'(1) - idxp;
        end else begin
            px = side_reg ? (tb_reg - idxp) : (idxp - tb_reg);
            py = '0;
        end
    end

    assign pix_ok    = (cnt_reg != '0) && (idx_reg < plen_reg);
    assign stall     = pend_valid_reg && out_valid_reg && !m_tready;
    assign div_start = (state_reg == ST_MUL);
    assign div_num   = (DUR_W+SW)'(elapsed_reg) * (DUR_W+SW)'(sum_reg);

    bsf_div #(
        .QW (SW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (cfg_dur_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // bottom row of the matrix
    function automatic logic [COORD_W-1:0] py_center(input logic [PW-1:0] hv);
        logic [PW-1:0] r;
        begin
            r = hv - PW'(1);
            return r[COORD_W-1:0];
        end
    endfunction

    // sequencer
    always_comb begin
        state_next      = state_reg;
        running_next    = running_reg;
        elapsed_next    = elapsed_reg;
        color_next      = color_reg;
        center_next     = center_reg;
        side_next       = side_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        len_next        = len_reg;
        plen_next       = plen_reg;
        sum_next        = sum_reg;
        b1_next         = b1_reg;
        b2_next         = b2_reg;
        bb_next         = bb_reg;
        sx_next         = sx_reg;
        tb_next         = tb_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_color_next  = out_color_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_mode)
                        MODE_START:  running_next = 1'b1;
                        MODE_CANCEL: running_next = 1'b0;
                        MODE_FRAME: begin
                            if (running_reg) begin
                                if (in_elapsed >= cfg_dur_reg) begin
                                    running_next = 1'b0;
                                end else begin
                                    elapsed_next = in_elapsed;
                                    color_next   = in_color;
                                    center_next  = ten_e < three_d;
                                    side_next    = 1'b0;
                                    w_next       = w_clamp;
                                    h_next       = h_clamp;
                                    len_next     = len_clamp;
                                    state_next   = ST_SETUP;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SETUP: begin
                plen_next  = plenc[SW-1:0];
                sum_next   = plenc[SW-1:0] + SW'(len_reg);
                b1_next    = b1c;
                b2_next    = b2c;
                bb_next    = side_reg ? (cp + PW'(1)) : (cp - PW'(1));
                sx_next    = side_reg ? (wp - PW'(1)) : '0;
                tb_next    = side_reg ? (wp - PW'(2) + b2c) : (b2c - PW'(1));
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    idx_next   = div_quot;
                    cnt_next   = len_reg;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (cnt_reg == '0) begin
                    if (!side_reg) begin
                        side_next  = 1'b1;
                        state_next = ST_SETUP;
                    end else begin
                        state_next = ST_CENTER;
                    end
                end else if (!(pix_ok && stall)) begin
                    if (pix_ok) begin
                        // the previous pending pixel is not the last one
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_x_next     = pend_x_reg;
                            out_y_next     = pend_y_reg;
                            out_color_next = color_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_x_next     = px[COORD_W-1:0];
                        pend_y_next     = py[COORD_W-1:0];
                    end
                    // trail stops below index zero
                    if (idx_reg == '0) begin
                        cnt_next = '0;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            ST_CENTER: begin
                if (!center_reg) begin
                    state_next = ST_FLUSH;
                end else if (!stall) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_x_next     = pend_x_reg;
                        out_y_next     = pend_y_reg;
                        out_color_next = color_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_x_next     = cp[COORD_W-1:0];
                    pend_y_next     = py_center(hp);
                    state_next      = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (!(out_valid_reg && !m_tready)) begin
                    out_valid_next  = 1'b1;
                    out_x_next      = pend_x_reg;
                    out_y_next      = pend_y_reg;
                    out_color_next  = color_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg   <= WIDTH_RST;
            cfg_h_reg   <= HEIGHT_RST;
            cfg_len_reg <= LENGTH_RST;
            cfg_dur_reg <= DURATION_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WIDTH:    cfg_w_reg   <= cfg_data[WREG_W-1:0];
                REG_HEIGHT:   cfg_h_reg   <= cfg_data[HREG_W-1:0];
                REG_LENGTH:   cfg_len_reg <= cfg_data[LREG_W-1:0];
                REG_DURATION: cfg_dur_reg <= cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            running_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            side_reg       <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            side_reg       <= side_next;
            cnt_reg        <= cnt_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        elapsed_reg   <= elapsed_next;
        color_reg     <= color_next;
        center_reg    <= center_next;
        w_reg         <= w_next;
        h_reg         <= h_next;
        len_reg       <= len_next;
        plen_reg      <= plen_next;
        sum_reg       <= sum_next;
        b1_reg        <= b1_next;
        b2_reg        <= b2_next;
        bb_reg        <= bb_next;
        sx_reg        <= sx_next;
        tb_reg        <= tb_next;
        idx_reg       <= idx_next;
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(M_TDATA_W - PIX_BITS)'(0), out_color_reg, out_y_reg, out_x_reg};

endmodule

// ===== rtl/core/bsf_checker.sv =====
module bsf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [bsf_pkg::MODE_W-1:0]    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bsf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import bsf_pkg::*;

    // a held pixel transaction keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("pixel changed while stalled");

    // start, cancel and unused events leave the block ready
    a_ctrl_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != MODE_FRAME |=> s_tready)
        else $error("block busy after a non-frame event");

    // padding above the pixel fields is zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:PIX_BITS] == '0)
        else $error("nonzero padding in pixel data");

    // reset leaves the block idle with nothing to send
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind border_snake_frame_generator bsf_checker u_bsf_checker (.*);

// ===== verif/testbench.sv =====
module testbench;
    import bsf_pkg::*;

    // unused event kind, the block must ignore it
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic [ELAPSED_W-1:0] MAX_ELAPSED = '1;
    localparam int SETTLE_CYCLES  = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 100;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [ELAPSED_W-1:0] elapsed;
        logic [COLOR_W-1:0]   color;
    } snake_event_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [MODE_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // stimulus and expectations
    snake_event_t pending_events[$];
    snake_event_t driven_event;
    pixel_t       expected_pixels[$];
    pixel_t       frame_px[$];

    // shadow of the block's registers and armed flag
    logic [WREG_W-1:0]  cfg_w   = WIDTH_RST;
    logic [HREG_W-1:0]  cfg_h   = HEIGHT_RST;
    logic [LREG_W-1:0]  cfg_len = LENGTH_RST;
    logic [DUR_W-1:0]   cfg_dur = DURATION_RST;
    bit                 armed   = 1'b0;

    bit src_idle   = 1'b0;
    bit sink_idle  = 1'b0;
    bit hold_req   = 1'b0;
    bit hold_taken = 1'b0;
    int src_gap    = 0;
    int stall_left = 0;
    int hold_left  = 0;
    int quiet      = 0;
    int mismatches = 0;

    border_snake_frame_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 6) != 0) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch on %0s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // coordinates of one index along the left or right border path
    function automatic void path_point(input bit go_left, input int unsigned w,
                                       input int unsigned h, input int unsigned idx,
                                       output logic [COORD_W-1:0] px,
                                       output logic [COORD_W-1:0] py);
        int unsigned c;
        int unsigned a;
        c = w / 2;
        a = w - 1 - c;
        if (go_left) begin
            if (idx < c) begin
                px = COORD_W'(c - 1 - idx);
                py = COORD_W'(h - 1);
            end else if (idx - c < h - 1) begin
                px = '0;
                py = COORD_W'(h - 2 - (idx - c));
            end else begin
                px = COORD_W'(idx - c - (h - 1) + 1);
                py = '0;
            end
        end else begin
            if (idx < a) begin
                px = COORD_W'(c + 1 + idx);
                py = COORD_W'(h - 1);
            end else if (idx - a < h - 1) begin
                px = COORD_W'(w - 1);
                py = COORD_W'(h - 2 - (idx - a));
            end else begin
                px = COORD_W'(w - 2 - (idx - a - (h - 1)));
                py = '0;
            end
        end
    endfunction

    // pixels of one snake, head first, clipped to the path
    function automatic void add_snake(input bit go_left, input int unsigned w,
                                      input int unsigned h,
                                      input logic [ELAPSED_W-1:0] elapsed,
                                      input logic [COLOR_W-1:0] color);
        int unsigned c;
        int unsigned plen;
        int unsigned k;
        longint unsigned head;
        longint unsigned idx;
        pixel_t p;
        c = w / 2;
        plen = go_left ? 2 * c + h - 1 : 2 * (w - 1 - c) + h - 1;
        head = (64'(elapsed) * 64'(plen + cfg_len)) / 64'(cfg_dur);
        for (k = 0; k < cfg_len; k++) begin
            if (head < k) break;
            idx = head - k;
            if (idx < plen) begin
                path_point(go_left, w, h, 32'(idx), p.x, p.y);
                p.color = color;
                p.last  = 1'b0;
                frame_px = {frame_px, p};
            end
        end
    endfunction

    // expected pixels for one accepted event, updates the armed flag
    function automatic void predict_pixels(input snake_event_t ev);
        int unsigned w;
        int unsigned h;
        pixel_t p;
        frame_px.delete();
        case (ev.mode)
            MODE_START:  armed = 1'b1;
            MODE_CANCEL: armed = 1'b0;
            MODE_FRAME: begin
                if (armed) begin
                    if (ev.elapsed >= cfg_dur) begin
                        armed = 1'b0;
                    end else begin
                        w = cfg_w < 2 ? 2 : (cfg_w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : cfg_w);
                        h = cfg_h < 2 ? 2 : (cfg_h > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : cfg_h);
                        add_snake(1'b1, w, h, ev.elapsed, ev.color);
                        add_snake(1'b0, w, h, ev.elapsed, ev.color);
                        // bottom-center pixel during the first 30 percent
                        if (64'(ev.elapsed) * 10 < 64'(cfg_dur) * 3) begin
                            p.x     = COORD_W'(w / 2);
                            p.y     = COORD_W'(h - 1);
                            p.color = ev.color;
                            p.last  = 1'b0;
                            frame_px = {frame_px, p};
                        end
                    end
                end
            end
            default: ;
        endcase
        if (frame_px.size() != 0) frame_px[frame_px.size() - 1].last = 1'b1;
        expected_pixels = {expected_pixels, frame_px};
    endfunction

    // input driver
    always @(posedge aclk) begin : drive_events
        snake_event_t ev;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) predict_pixels(driven_event);
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    ev = pending_events.pop_front();
                    driven_event <= ev;
                    s_tvalid     <= 1'b1;
                    s_tdata      <= {2'b00, ev.color, ev.elapsed};
                    s_tuser      <= ev.mode;
                    src_gap      <= (src_idle && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor and receiver stalls
    always @(posedge aclk) begin : watch_pixels
        pixel_t want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("pixel with none pending", m_tdata, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata[COORD_W-1:0] !== want.x)
                        report_mismatch("pixel_x", m_tdata[COORD_W-1:0], want.x);
                    if (m_tdata[2*COORD_W-1:COORD_W] !== want.y)
                        report_mismatch("pixel_y", m_tdata[2*COORD_W-1:COORD_W], want.y);
                    if (m_tdata[PIX_BITS-1:2*COORD_W] !== want.color)
                        report_mismatch("pixel_color", m_tdata[PIX_BITS-1:2*COORD_W],
                                        want.color);
                    if (m_tlast !== want.last)
                        report_mismatch("last_pixel", m_tlast, want.last);
                end
            end
            // one long hold-off on request, else random short and long stalls
            if (hold_req && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                m_tready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 3) == 0) begin
                stall_left <= pick_gap() - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_event(input logic [MODE_W-1:0] mode,
                              input logic [ELAPSED_W-1:0] elapsed,
                              input logic [COLOR_W-1:0] color);
        snake_event_t ev;
        ev.mode    = mode;
        ev.elapsed = elapsed;
        ev.color   = color;
        pending_events = {pending_events, ev};
    endtask

    // one register write, valid stays high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_WIDTH:    cfg_w   = val[WREG_W-1:0];
            REG_HEIGHT:   cfg_h   = val[HREG_W-1:0];
            REG_LENGTH:   cfg_len = val[LREG_W-1:0];
            REG_DURATION: cfg_dur = val[DUR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] len,
                              input logic [CFG_DATA_W-1:0] dur);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_LENGTH, len);
        write_reg(REG_DURATION, dur);
        cfg_valid <= 1'b0;
    endtask

    // wait for the block to go idle, sampled between clock edges
    task automatic drain();
        while (pending_events.size() != 0 || s_tvalid || expected_pixels.size() != 0 ||
               !s_tready || m_tvalid)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [ELAPSED_W-1:0] elapsed_in_run();
        if (cfg_dur == 0) return ELAPSED_W'($urandom);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ELAPSED_W'(cfg_dur - 1);
            default: return ELAPSED_W'($urandom % cfg_dur);
        endcase
    endfunction

    function automatic logic [ELAPSED_W-1:0] elapsed_past_end();
        if (cfg_dur == MAX_ELAPSED) return MAX_ELAPSED;
        return cfg_dur + ELAPSED_W'($urandom % (32'(MAX_ELAPSED) - cfg_dur + 1));
    endfunction

    // mostly start/frames/end runs, some noise events
    task automatic gen_random(input int n);
        int made;
        int k;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 9) < 7) begin
                push_event(MODE_START, ELAPSED_W'($urandom), COLOR_W'($urandom));
                k = $urandom_range(1, 5);
                repeat (k) push_event(MODE_FRAME, elapsed_in_run(), COLOR_W'($urandom));
                case ($urandom_range(0, 3))
                    0: begin
                        push_event(MODE_FRAME, elapsed_past_end(), COLOR_W'($urandom));
                        made++;
                    end
                    1: begin
                        push_event(MODE_CANCEL, ELAPSED_W'($urandom), COLOR_W'($urandom));
                        made++;
                    end
                    default: ;
                endcase
                made += k + 1;
            end else begin
                push_event(MODE_W'($urandom_range(0, 3)), ELAPSED_W'($urandom),
                           COLOR_W'($urandom));
                made++;
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] len,
                             input logic [CFG_DATA_W-1:0] dur,
                             input bit src_gaps, input bit sink_gaps, input bit hold,
                             input int n);
        set_config(w, h, len, dur);
        src_idle  <= src_gaps;
        sink_idle <= sink_gaps;
        if (hold) hold_req <= 1'b1;
        gen_random(n);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers: zero duration ends every frame at once
        push_event(MODE_START, '0, '0);
        push_event(MODE_FRAME, '0, '1);
        push_event(MODE_FRAME, 22'd7, 24'h123456);
        push_event(MODE_SPARE, '1, '1);
        drain();

        // only the duration written, sizes stay at reset values
        write_reg(REG_DURATION, 22'd1000);
        cfg_valid <= 1'b0;
        src_idle  <= 1'b1;
        sink_idle <= 1'b1;
        push_event(MODE_START, '0, '0);
        push_event(MODE_START, '1, '1);
        push_event(MODE_FRAME, 22'd0, 24'h000000);
        push_event(MODE_FRAME, 22'd299, 24'hFFFFFF);
        push_event(MODE_FRAME, 22'd300, 24'hA5C35A);
        push_event(MODE_FRAME, 22'd999, 24'h0F0F0F);
        push_event(MODE_FRAME, 22'd1000, 24'h777777);
        push_event(MODE_FRAME, 22'd5, 24'h111111);
        push_event(MODE_START, '0, '0);
        push_event(MODE_CANCEL, '1, '1);
        push_event(MODE_FRAME, 22'd5, 24'h222222);
        push_event(MODE_SPARE, 22'd10, 24'h333333);
        push_event(MODE_START, '0, '0);
        push_event(MODE_SPARE, '1, '1);
        push_event(MODE_FRAME, 22'd500, 24'h5A5A5A);
        push_event(MODE_FRAME, '1, 24'h444444);
        drain();

        // smallest matrix, longest duration
        set_config(22'd2, 22'd2, 22'd1, MAX_ELAPSED);
        push_event(MODE_START, '0, '0);
        push_event(MODE_FRAME, MAX_ELAPSED - 1, 24'hFFFFFF);
        push_event(MODE_FRAME, MAX_ELAPSED, 24'h000000);
        gen_random(12);
        drain();

        // largest sizes, receiver holds off so the block backs up
        run_phase(22'd64, 22'd64, 22'd31, MAX_ELAPSED, 1'b0, 1'b1, 1'b1, 18);
        // sizes below range and zero snake length
        run_phase(22'd0, 22'd1, 22'd0, 22'd5000, 1'b1, 1'b1, 1'b0, 14);
        // sizes above range, no idling on either side
        run_phase(22'd127, 22'd127, 22'd31, 22'd777, 1'b0, 1'b0, 1'b0, 14);
        // odd width, short duration
        run_phase(22'd15, 22'd3, 22'd5, 22'd60, 1'b1, 1'b0, 1'b0, 12);
        // narrow and tall, one-millisecond duration
        run_phase(22'd3, 22'd64, 22'd2, 22'd1, 1'b1, 1'b1, 1'b0, 12);
        // random registers, junk in the upper data bits
        run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom_range(1, 300)), 1'b1, 1'b1, 1'b0, 14);
        run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom_range(1, 4194303)), 1'b1, 1'b1, 1'b0, 14);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
